>>> rtl/spv_pkg.sv
// Shared types and constants for the stepped PWM voltage regulator.
package spv_pkg;

  localparam int MV_W   = 15;
  localparam int DUTY_W = 10;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int STEP_W = 3;

  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_HOLD   = 3'd1;
  localparam logic [2:0] REG_DEAD   = 3'd2;
  localparam logic [2:0] REG_COARSE = 3'd3;
  localparam logic [2:0] REG_MEDIUM = 3'd4;
  localparam logic [2:0] REG_DMAX   = 3'd5;
  localparam logic [2:0] REG_DMIN   = 3'd6;

  localparam logic [MV_W-1:0]   TARGET_RST = 15'd24000;
  localparam logic [MV_W-1:0]   HOLD_RST   = 15'd100;
  localparam logic [MV_W-1:0]   DEAD_RST   = 15'd50;
  localparam logic [MV_W-1:0]   COARSE_RST = 15'd1000;
  localparam logic [MV_W-1:0]   MEDIUM_RST = 15'd200;
  localparam logic [DUTY_W-1:0] DMAX_RST   = 10'd550;
  localparam logic [DUTY_W-1:0] DMIN_RST   = 10'd6;
  localparam logic [DUTY_W-1:0] LEVEL_RST  = 10'd8;

  localparam logic [STEP_W-1:0] STEP_COARSE = 3'd6;
  localparam logic [STEP_W-1:0] STEP_MEDIUM = 3'd2;
  localparam logic [STEP_W-1:0] STEP_FINE   = 3'd1;

  typedef struct packed {
    logic [MV_W-1:0]   target_mv;
    logic [MV_W-1:0]   hold_band_mv;
    logic [MV_W-1:0]   dead_band_mv;
    logic [MV_W-1:0]   coarse_threshold_mv;
    logic [MV_W-1:0]   medium_threshold_mv;
    logic [DUTY_W-1:0] duty_max;
    logic [DUTY_W-1:0] duty_min;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] compare_value;
    logic              in_band;
  } res_t;

endpackage

>>> rtl/spv_if.sv
// Valid/ready channel interfaces for samples and results.
interface spv_sample_if;
  import spv_pkg::*;
  logic            valid;
  logic            ready;
  logic [MV_W-1:0] measured_mv;
  modport source (output valid, output measured_mv, input ready);
  modport sink (input valid, input measured_mv, output ready);
endinterface

interface spv_result_if;
  import spv_pkg::*;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] compare_value;
  logic              in_band;
  modport source (output valid, output compare_value, output in_band, input ready);
  modport sink (input valid, input compare_value, input in_band, output ready);
endinterface

>>> rtl/spv_cfg.sv
// APB register bank holding the regulator thresholds and clamps.
module spv_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spv_pkg::ADDR_W-1:0]  paddr,
  input  logic [spv_pkg::DATA_W-1:0]  pwdata,
  output logic [spv_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output spv_pkg::cfg_t               cfg
);
  import spv_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_mv           <= TARGET_RST;
      cfg.hold_band_mv        <= HOLD_RST;
      cfg.dead_band_mv        <= DEAD_RST;
      cfg.coarse_threshold_mv <= COARSE_RST;
      cfg.medium_threshold_mv <= MEDIUM_RST;
      cfg.duty_max            <= DMAX_RST;
      cfg.duty_min            <= DMIN_RST;
    end else if (wr) begin
      case (idx)
        REG_TARGET: cfg.target_mv           <= pwdata[MV_W-1:0];
        REG_HOLD:   cfg.hold_band_mv        <= pwdata[MV_W-1:0];
        REG_DEAD:   cfg.dead_band_mv        <= pwdata[MV_W-1:0];
        REG_COARSE: cfg.coarse_threshold_mv <= pwdata[MV_W-1:0];
        REG_MEDIUM: cfg.medium_threshold_mv <= pwdata[MV_W-1:0];
        REG_DMAX:   cfg.duty_max            <= pwdata[DUTY_W-1:0];
        REG_DMIN:   cfg.duty_min            <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_TARGET: prdata = {{(DATA_W-MV_W){1'b0}}, cfg.target_mv};
      REG_HOLD:   prdata = {{(DATA_W-MV_W){1'b0}}, cfg.hold_band_mv};
      REG_DEAD:   prdata = {{(DATA_W-MV_W){1'b0}}, cfg.dead_band_mv};
      REG_COARSE: prdata = {{(DATA_W-MV_W){1'b0}}, cfg.coarse_threshold_mv};
      REG_MEDIUM: prdata = {{(DATA_W-MV_W){1'b0}}, cfg.medium_threshold_mv};
      REG_DMAX:   prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg.duty_max};
      REG_DMIN:   prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg.duty_min};
      default:    prdata = '0;
    endcase
  end

endmodule

>>> rtl/spv_core.sv
// Error evaluation, duty stepping, clamping and hold latch state.
module spv_core (
  input  logic                      clk,
  input  logic                      rst,
  input  spv_pkg::cfg_t             cfg,
  input  logic                      advance,
  input  logic [spv_pkg::MV_W-1:0]  measured_mv,
  output spv_pkg::res_t             res,
  output logic                      hold_hit,
  output logic                      locked
);
  import spv_pkg::*;

  logic [DUTY_W-1:0]        drive_level;
  logic [DUTY_W-1:0]        held_level;
  logic [DUTY_W-1:0]        drive_level_next;
  logic signed [MV_W:0]     err;
  logic signed [MV_W:0]     neg_err;
  logic signed [MV_W:0]     dead_pos;
  logic signed [MV_W:0]     dead_neg;
  logic [MV_W-1:0]          mag;
  logic [STEP_W-1:0]        step;
  logic signed [DUTY_W+1:0] level;
  logic signed [DUTY_W+1:0] lim_max;
  logic signed [DUTY_W+1:0] lim_min;
  logic signed [DUTY_W+1:0] level_hi;

  always_comb begin
    err      = $signed({1'b0, cfg.target_mv}) - $signed({1'b0, measured_mv});
    neg_err  = -err;
    mag      = err[MV_W] ? neg_err[MV_W-1:0] : err[MV_W-1:0];
    hold_hit = (mag <= cfg.hold_band_mv);
    dead_pos = $signed({1'b0, cfg.dead_band_mv});
    dead_neg = -dead_pos;

    if (mag > cfg.coarse_threshold_mv) begin
      step = STEP_COARSE;
    end else if (mag > cfg.medium_threshold_mv) begin
      step = STEP_MEDIUM;
    end else begin
      step = STEP_FINE;
    end

    level = $signed({2'b00, drive_level});
    if (err > dead_pos) begin
      level = level + $signed({{(DUTY_W-STEP_W+2){1'b0}}, step});
    end else if (err < dead_neg) begin
      level = level - $signed({{(DUTY_W-STEP_W+2){1'b0}}, step});
    end

    lim_max  = $signed({2'b00, cfg.duty_max});
    lim_min  = $signed({2'b00, cfg.duty_min});
    level_hi = (level > lim_max) ? lim_max : level;
    drive_level_next = (level_hi < lim_min) ? cfg.duty_min : level_hi[DUTY_W-1:0];

    if (hold_hit) begin
      res.compare_value = locked ? held_level : drive_level;
      res.in_band       = 1'b1;
    end else begin
      res.compare_value = drive_level_next;
      res.in_band       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_level <= LEVEL_RST;
      held_level  <= LEVEL_RST;
      locked      <= 1'b0;
    end else if (advance) begin
      if (hold_hit) begin
        if (!locked) begin
          held_level <= drive_level;
          locked     <= 1'b1;
        end
      end else begin
        locked      <= 1'b0;
        drive_level <= drive_level_next;
      end
    end
  end

endmodule

>>> rtl/stepped_pwm_voltage_regulator_top.sv
// Top level of the stepped PWM voltage regulator.
//
//   Port      Dir    Beat contents
//   sample    in     measured_mv (15 b, mV)
//   result    out    compare_value (10 b), in_band (1 b)
//   APB       in/out register writes and reads, 32-bit data
//
// One beat per cycle sustained while the result side accepts; a sample is
// taken into the input register, then its result is loaded from spv_core
// (as the core's drive level updates) into the result register and offered.
// The drive level loop closes through the drive_level register in spv_core.
// Synchronous reset clears valids, core state and config registers; the data
// registers are not reset. A stalled result holds the input register, which
// takes beats while empty or handing its sample on in the same cycle.
module stepped_pwm_voltage_regulator_top (
  input  logic                        clk,
  input  logic                        rst,
  spv_sample_if.sink                  sample,
  spv_result_if.source                result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spv_pkg::ADDR_W-1:0]  paddr,
  input  logic [spv_pkg::DATA_W-1:0]  pwdata,
  output logic [spv_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import spv_pkg::*;

  cfg_t            cfg;
  res_t            core_res;
  res_t            out_res;
  logic            out_valid;
  logic            s1_valid;
  logic [MV_W-1:0] s1_meas;
  logic            s1_adv;
  logic            hold_hit;
  logic            locked;

  spv_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spv_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .advance     (s1_adv),
    .measured_mv (s1_meas),
    .res         (core_res),
    .hold_hit    (hold_hit),
    .locked      (locked)
  );

  assign s1_adv       = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (sample.ready) begin
        s1_valid <= sample.valid;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_meas <= sample.measured_mv;
    end
    if (s1_adv) begin
      out_res <= core_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.compare_value = out_res.compare_value;
  assign result.in_band       = out_res.in_band;

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("input register dropped a waiting sample");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("result register not loaded after advance");

  a_lock_set: assert property (@(posedge clk) disable iff (rst)
    s1_adv && hold_hit |=> locked)
    else $error("hold latch not set after an in-band sample");

  a_lock_clr: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !hold_hit |=> !locked)
    else $error("hold latch not cleared after an out-of-band sample");

endmodule
